>>> rtl/flq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the fetch latency queue.
// No dependencies; imported by flq_cell and fetch_latency_queue_core.
package flq_pkg;

  localparam int ADDR_W = 32;
  localparam int CD_W   = 4;
  localparam int POS_W  = 4;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              add;
    logic              remove;
    logic [ADDR_W-1:0] match_addr;
    logic [ADDR_W-1:0] new_addr;
    logic [CD_W-1:0]   new_cd;
  } cell_ctrl_t;

endpackage

>>> rtl/flq_cell.sv
`timescale 1ns / 1ps
// One queue slot: address and latency countdown, shifting toward the head.
// Depends on flq_pkg.
module flq_cell import flq_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              valid,
  input  logic              load,
  input  logic [ADDR_W-1:0] nb_addr,
  input  logic [CD_W-1:0]   nb_cd,
  input  logic              seen_in,
  output logic [ADDR_W-1:0] addr,
  output logic [CD_W-1:0]   cd,
  output logic              seen_out,
  output logic              not_ready
);

  logic match;
  logic [ADDR_W-1:0] addr_next;
  logic [CD_W-1:0]   cd_next;

  assign match     = valid && (addr == ctrl.match_addr);
  assign seen_out  = seen_in || match;
  assign not_ready = valid && (cd > CD_W'(1));

  always_comb begin
    addr_next = addr;
    cd_next   = cd;
    if (load) begin
      addr_next = ctrl.new_addr;
      cd_next   = ctrl.new_cd;
    end else if (ctrl.add && valid && (cd != '0)) begin
      cd_next = cd - CD_W'(1);
    end else if (ctrl.remove && seen_out) begin
      // close the gap behind the removed entry
      addr_next = nb_addr;
      cd_next   = nb_cd;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    cd   <= cd_next;
  end

endmodule

>>> rtl/fetch_latency_queue_core.sv
`timescale 1ns / 1ps
// Top level of the fetch latency queue: a chain of flq_cell slots plus
// the entry count, peek selection and the result register. Uses flq_pkg.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------
//  s_*      | in  | s_tvalid / s_tready | tuser: func; tdata: addr, position
//  m_*      | out | m_tvalid / m_tready | tdata: status, found_addr
//  cfg_*    | in  | cfg_we              | cfg_wdata: fetch_latency
//
// Every operation finishes in the cycle it is accepted; one beat per cycle while the output register can take it.
// This rests on every slot in the chain updating in the same cycle.
// The result sits in one output register; a new beat is taken when that
// register is empty or being drained the same cycle.
// rst (synchronous) empties the queue and sets fetch_latency to 1.
module fetch_latency_queue_core import flq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] instr_addr, [35:32] position, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [33:2] found_addr, rest zero
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CD_W-1:0]   fetch_latency;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              acc;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] in_addr;
  logic [POS_W-1:0]  position;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     count_ext;
  logic              full;
  logic              hit;
  logic              blocked;
  logic [ADDR_W-1:0] sel_addr;
  logic [STAT_W-1:0] status;
  logic [STAT_W-1:0] status_next;
  logic [ADDR_W-1:0] found_addr;
  logic [ADDR_W-1:0] found_next;
  cell_ctrl_t        ctrl;

  logic [ADDR_W-1:0] c_addr [QUEUE_DEPTH];
  logic [CD_W-1:0]   c_cd   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   seen;
  logic [QUEUE_DEPTH-1:0] c_nrdy;
  logic [QUEUE_DEPTH-1:0] c_blk;
  logic [QUEUE_DEPTH-1:0] c_valid;

  assign func     = s_tuser;
  assign in_addr  = s_tdata[31:0];
  assign position = s_tdata[35:32];
  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  assign full      = (count == CW'(QUEUE_DEPTH));

  assign ctrl.add        = acc && (func == FUNC_ADD);
  assign ctrl.remove     = acc && (func == FUNC_REMOVE);
  assign ctrl.match_addr = in_addr;
  assign ctrl.new_addr   = in_addr;
  assign ctrl.new_cd     = fetch_latency;

  assign seen[0] = 1'b0;
  assign hit     = seen[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1 < QUEUE_DEPTH) ? i + 1 : i;
    logic load;
    assign c_valid[i] = PW'(i) < count_ext;
    assign load       = ctrl.add && !full && (count == CW'(i));
    assign c_blk[i]   = c_nrdy[i] && (PW'(i) <= pos_ext);

    flq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (c_valid[i]),
      .load      (load),
      .nb_addr   (c_addr[NB]),
      .nb_cd     (c_cd[NB]),
      .seen_in   (seen[i]),
      .addr      (c_addr[i]),
      .cd        (c_cd[i]),
      .seen_out  (seen[i+1]),
      .not_ready (c_nrdy[i])
    );
  end

  assign blocked = |c_blk;

  always_comb begin
    sel_addr = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pos_ext == PW'(i)) begin
        sel_addr = sel_addr | c_addr[i];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = STAT_OK;
    found_next  = '0;
    case (func)
      FUNC_ADD: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      FUNC_PEEK: begin
        if ((pos_ext < count_ext) && !blocked) begin
          found_next = sel_addr;
        end else begin
          status_next = STAT_MISS;
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          count_next = count - CW'(1);
        end else begin
          status_next = STAT_MISS;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_latency <= CD_W'(1);
      count         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        fetch_latency <= cfg_wdata;
      end
      if (acc) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (acc) begin
      status     <= status_next;
      found_addr <= found_next;
    end
  end

  assign m_tdata = {6'd0, found_addr, status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == FUNC_FLUSH)) |=> (count == '0))
    else $error("flush left entries in the queue");

  a_full_add: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == FUNC_ADD) && full) |=> ((status == STAT_FULL) && full))
    else $error("add on full queue not reported");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == FUNC_REMOVE))
      |=> ((status == STAT_OK) == (count == $past(count) - CW'(1))))
    else $error("remove status and entry count disagree");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status != STAT_OK)) |-> (found_addr == '0))
    else $error("address returned with a failing status");

endmodule
